FILE: design/wcbt_pkg.sv
// Shared types and codes for the worker circuit breaker table.
package wcbt_pkg;

  // Command codes carried by an input transaction.
  localparam logic [2:0] CMD_SELECT  = 3'd0;
  localparam logic [2:0] CMD_COORD   = 3'd1;
  localparam logic [2:0] CMD_WORKER  = 3'd2;
  localparam logic [2:0] CMD_FAIL    = 3'd3;
  localparam logic [2:0] CMD_RESTORE = 3'd4;

  // Breaker modes.
  localparam logic [1:0] MODE_CLOSED = 2'd0;
  localparam logic [1:0] MODE_HALF   = 2'd1;
  localparam logic [1:0] MODE_OPEN   = 2'd2;

  // Failure cause that opens the breaker at once.
  localparam logic [1:0] KIND_HOSTDOWN = 2'd1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT      = 2'd1;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [7:0]  THRESHOLD_RESET = 8'd3;
  localparam logic [15:0] WAIT_RESET      = 16'd10;

  // One table entry without its open timestamp.
  typedef struct packed {
    logic       known;
    logic [1:0] mode;
    logic       checking;
    logic [7:0] fail;
  } entry_t;

endpackage

FILE: design/worker_circuit_breaker_table_unit.sv
// Top level of the worker circuit breaker table: entry memories, update logic and result register.
//
// The block takes one command transaction per clock cycle when busy is low, and its result
// appears on the out_ ports with out_valid high for exactly one cycle, after the transaction has
// passed the update stage and the result register; the receiver cannot stall, so results must
// be taken as they come. The figure of one transaction per cycle is set by the single
// read-modify-write of the entry memory, whose registered read is bypassed when consecutive
// transactions hit the same worker. After reset, busy stays high while a clearing pass zeroes
// the mode/count/flags memory, one entry per cycle; configuration writes are taken during that
// pass and are always ready.
module worker_circuit_breaker_table_unit #(
  parameter int unsigned WORKER_SLOTS = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Command channel.
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       in_cmd,
  input  logic [7:0]                       in_worker_index,
  input  logic [31:0]                      in_now_seconds,
  input  logic [1:0]                       in_error_kind,
  input  logic                             in_last_in_shard,
  // Result channel.
  output logic                             out_valid,
  output logic                             out_healthy,
  output logic                             out_shard_none_healthy,
  output logic [1:0]                       out_breaker_state,
  output logic [7:0]                       out_fail_total,
  // Configuration write channel.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wcbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wcbt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned AW = (WORKER_SLOTS > 1) ? $clog2(WORKER_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(WORKER_SLOTS - 1);

  // Entry memories: mode/count/flags, and the time each entry opened.
  wcbt_pkg::entry_t ent_mem [WORKER_SLOTS];
  logic [31:0]      open_mem [WORKER_SLOTS];

  // Configuration registers.
  logic [7:0]  threshold_r;
  logic [15:0] wait_r;

  // Clearing pass.
  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  // Transaction held during its update cycle.
  logic          s_valid_r;
  logic [2:0]    s_cmd_r;
  logic [AW-1:0] s_addr_r;
  logic          s_inrange_r;
  logic [31:0]   s_now_r;
  logic [1:0]    s_kind_r;
  logic          s_last_r;

  // Memory read data and bypass of the write made at the same edge.
  wcbt_pkg::entry_t ent_rd_r;
  logic [31:0]      open_rd_r;
  logic             fwd_hit_r;
  wcbt_pkg::entry_t fwd_ent_r;
  logic [31:0]      fwd_open_r;

  logic shard_any_r;
  logic shard_any_nxt;

  // Result register.
  logic       out_valid_r;
  logic       out_healthy_r;
  logic       out_none_r;
  logic [1:0] out_state_r;
  logic [7:0] out_fail_r;

  logic          accept;
  logic [AW-1:0] in_addr;
  logic          in_range;

  wcbt_pkg::entry_t cur;
  logic [31:0]      cur_open;
  wcbt_pkg::entry_t ent_nxt;
  logic [31:0]      open_nxt;
  logic             known;
  logic             known_after;
  logic             healthy;
  logic             none;
  logic [31:0]      elapsed;
  logic             wait_over;
  logic [8:0]       weight;
  logic [9:0]       sum;
  logic             wr_en;

  // Handshake and addressing.
  assign busy      = clearing_r;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_addr   = AW'(in_worker_index);
  assign in_range  = 32'(in_worker_index) < 32'(WORKER_SLOTS);

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= wcbt_pkg::THRESHOLD_RESET;
      wait_r      <= wcbt_pkg::WAIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == wcbt_pkg::CFG_THRESHOLD) begin
        threshold_r <= cfg_data[7:0];
      end else if (cfg_index == wcbt_pkg::CFG_WAIT) begin
        wait_r <= cfg_data[15:0];
      end
    end
  end

  // Clearing pass over the entry memory after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Capture an accepted transaction for its update cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      s_valid_r <= accept;
      if (accept) begin
        fwd_hit_r <= wr_en && (s_addr_r == in_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_cmd_r     <= in_cmd;
      s_addr_r    <= in_addr;
      s_inrange_r <= in_range;
      s_now_r     <= in_now_seconds;
      s_kind_r    <= in_error_kind;
      s_last_r    <= in_last_in_shard;
      fwd_ent_r   <= ent_nxt;
      fwd_open_r  <= open_nxt;
    end
  end

  // Memory reads, issued at acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      ent_rd_r  <= ent_mem[in_addr];
      open_rd_r <= open_mem[in_addr];
    end
  end

  // Memory writes: the clearing pass, or the write-back of the current transaction.
  assign wr_en = s_valid_r && s_inrange_r;

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      ent_mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      ent_mem[s_addr_r] <= ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      open_mem[s_addr_r] <= open_nxt;
    end
  end

  // Entry as seen by this transaction, with the previous write bypassed in.
  assign cur      = fwd_hit_r ? fwd_ent_r : ent_rd_r;
  assign cur_open = fwd_hit_r ? fwd_open_r : open_rd_r;
  assign known    = s_inrange_r && cur.known;

  // Wait check and failure weighting.
  assign elapsed   = s_now_r - cur_open;
  assign wait_over = (cur.mode == wcbt_pkg::MODE_OPEN) && (elapsed > 32'(wait_r));
  assign weight    = (s_kind_r == wcbt_pkg::KIND_HOSTDOWN) ? (9'(threshold_r) + 9'd1) : 9'd1;
  assign sum       = 10'(cur.fail) + 10'(weight);

  // Command decode and entry update.
  always_comb begin
    ent_nxt       = cur;
    open_nxt      = cur_open;
    healthy       = 1'b0;
    none          = 1'b0;
    known_after   = known;
    shard_any_nxt = shard_any_r;
    case (s_cmd_r)
      wcbt_pkg::CMD_SELECT: begin
        if (!known || cur.mode == wcbt_pkg::MODE_CLOSED) begin
          healthy = 1'b1;
        end else if (cur.mode == wcbt_pkg::MODE_HALF && !cur.checking) begin
          healthy          = 1'b1;
          ent_nxt.checking = 1'b1;
        end
        if (healthy) begin
          shard_any_nxt = 1'b1;
        end
        if (s_last_r) begin
          none          = !shard_any_nxt;
          shard_any_nxt = 1'b0;
        end
      end
      wcbt_pkg::CMD_COORD: begin
        if (known && wait_over) begin
          ent_nxt.mode = wcbt_pkg::MODE_HALF;
          ent_nxt.fail = '0;
        end
      end
      wcbt_pkg::CMD_WORKER: begin
        if (known) begin
          // A half-open entry, or one whose wait just ran out, closes.
          if (wait_over || cur.mode == wcbt_pkg::MODE_HALF) begin
            ent_nxt.mode     = wcbt_pkg::MODE_CLOSED;
            ent_nxt.fail     = '0;
            ent_nxt.checking = 1'b0;
          end
        end else if (s_inrange_r) begin
          ent_nxt.known    = 1'b1;
          ent_nxt.mode     = wcbt_pkg::MODE_CLOSED;
          ent_nxt.fail     = '0;
          ent_nxt.checking = 1'b0;
          known_after      = 1'b1;
        end
      end
      wcbt_pkg::CMD_FAIL: begin
        if (known && cur.mode != wcbt_pkg::MODE_OPEN) begin
          if (sum > 10'(threshold_r) || cur.mode == wcbt_pkg::MODE_HALF) begin
            ent_nxt.mode     = wcbt_pkg::MODE_OPEN;
            ent_nxt.fail     = '0;
            ent_nxt.checking = 1'b0;
            open_nxt         = s_now_r;
          end else begin
            ent_nxt.fail = sum[7:0];
          end
        end
      end
      wcbt_pkg::CMD_RESTORE: begin
        if (known && cur.mode == wcbt_pkg::MODE_HALF) begin
          ent_nxt.checking = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Shard accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shard_any_r <= 1'b0;
    end else if (s_valid_r) begin
      shard_any_r <= shard_any_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid_r) begin
      out_healthy_r <= healthy;
      out_none_r    <= none;
      out_state_r   <= known_after ? ent_nxt.mode : wcbt_pkg::MODE_CLOSED;
      out_fail_r    <= known_after ? ent_nxt.fail : 8'd0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_healthy            = out_healthy_r;
  assign out_shard_none_healthy = out_none_r;
  assign out_breaker_state      = out_state_r;
  assign out_fail_total         = out_fail_r;

  // Every transaction in its update cycle gives a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s_valid_r |=> out_valid_r)
    else $error("update cycle without a following result");

  // No transaction is in flight while the clearing pass runs.
  a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !s_valid_r)
    else $error("transaction in flight during clearing pass");

  // A healthy select always sets the shard accumulator, so the shard cannot be empty.
  a_healthy_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_healthy_r && out_none_r))
    else $error("healthy result flagged an empty shard");

  // Open breakers never carry a fail count.
  a_open_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_state_r == wcbt_pkg::MODE_OPEN) |-> (out_fail_r == 8'd0))
    else $error("open breaker reported a nonzero fail count");

endmodule
